@@ hw/rtl/mpbs_pkg.sv @@
// shared types and constants for the memory/pim batch scheduler
// no dependencies; imported by every scheduler module

package mpbs_pkg;

    // scheduler mode codes
    localparam logic [2:0] MODE_WAIT  = 3'd0;
    localparam logic [2:0] MODE_MEM   = 3'd1;
    localparam logic [2:0] MODE_TOPIM = 3'd2;
    localparam logic [2:0] MODE_PIM   = 3'd3;
    localparam logic [2:0] MODE_TOMEM = 3'd4;

    // register map, word index taken from paddr[2]
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_BATCH_SIZE  = 1'b0;
    localparam logic REG_QUEUE_LIMIT = 1'b1;

    localparam logic [15:0] BATCH_SIZE_RST  = 16'd16;
    localparam logic [6:0]  QUEUE_LIMIT_RST = 7'd64;

    localparam int unsigned BUDGET_W = 32;

    typedef struct packed {
        logic [15:0] batch_size;
        logic [6:0]  queue_limit;
    } t_cfg;

    typedef struct packed {
        logic        trace_present;
        logic [31:0] trace_time;
        logic        trace_is_write;
        logic        next_present;
        logic [31:0] after_time;
        logic        read_blocked;
        logic        dram_accepts;
        logic [6:0]  retired_count;
        logic        pe_halted;
        logic        cpu_ready;
        logic        dram_drained;
    } t_tick;

    typedef struct packed {
        logic [2:0] mode;
        logic       issue;
        logic       dram_tick;
        logic       cpu_tick;
        logic       cpu_pause;
        logic       cpu_resume;
        logic       finished;
    } t_result;

endpackage

@@ hw/rtl/mem_pim_batch_scheduler.sv @@
// top level of the memory/pim batch scheduler
// depends on mpbs_pkg, mpbs_regs, mpbs_core, mpbs_out_reg
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_ready   trace head, next, dram/pim status
//  out       source     o_out_valid / i_out_ready mode plus issue/tick/pause/resume/finished
//  cfg       apb slave  psel, penable, pwrite     batch_size @0x0, queue_limit @0x4
//
//  one status tick per clock while out is not blocked; its result shows on the out channel
//  the cycle after transfer, from the result register behind the decision logic
//  reset is synchronous, active low; all scheduler state returns to wait_batch
//  a stalled consumer holds the result register; a new tick is taken the same
//  cycle the held result leaves, so the input only stalls while out is blocked

module mem_pim_batch_scheduler
    import mpbs_pkg::*;
#(
    parameter int unsigned CLOCK_WIDTH = 32,
    parameter int unsigned MAX_QUEUE   = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // tick input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_trace_present,
    input  logic [31:0]       i_trace_time,
    input  logic              i_trace_is_write,
    input  logic              i_next_present,
    input  logic [31:0]       i_after_time,
    input  logic              i_read_blocked,
    input  logic              i_dram_accepts,
    input  logic [6:0]        i_retired_count,
    input  logic              i_pe_halted,
    input  logic              i_cpu_ready,
    input  logic              i_dram_drained,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_mode,
    output logic              o_issue,
    output logic              o_dram_tick,
    output logic              o_cpu_tick,
    output logic              o_cpu_pause,
    output logic              o_cpu_resume,
    output logic              o_finished
);

    t_cfg    w_cfg;
    t_tick   w_tick;
    t_result w_next_result;
    t_result w_result;
    logic    w_free;
    logic    w_xfer;

    // gather input fields
    assign w_tick.trace_present  = i_trace_present;
    assign w_tick.trace_time     = i_trace_time;
    assign w_tick.trace_is_write = i_trace_is_write;
    assign w_tick.next_present   = i_next_present;
    assign w_tick.after_time     = i_after_time;
    assign w_tick.read_blocked   = i_read_blocked;
    assign w_tick.dram_accepts   = i_dram_accepts;
    assign w_tick.retired_count  = i_retired_count;
    assign w_tick.pe_halted      = i_pe_halted;
    assign w_tick.cpu_ready      = i_cpu_ready;
    assign w_tick.dram_drained   = i_dram_drained;

    // input transfer: state advances and the result register loads together
    assign o_in_ready = w_free;
    assign w_xfer     = i_in_valid && w_free;

    mpbs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mpbs_core #(
        .CLOCK_WIDTH (CLOCK_WIDTH),
        .MAX_QUEUE   (MAX_QUEUE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_xfer),
        .i_cfg    (w_cfg),
        .i_tick   (w_tick),
        .o_result (w_next_result)
    );

    mpbs_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_xfer),
        .i_result (w_next_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (w_free),
        .o_result (w_result)
    );

    // scatter result fields
    assign o_mode       = w_result.mode;
    assign o_issue      = w_result.issue;
    assign o_dram_tick  = w_result.dram_tick;
    assign o_cpu_tick   = w_result.cpu_tick;
    assign o_cpu_pause  = w_result.cpu_pause;
    assign o_cpu_resume = w_result.cpu_resume;
    assign o_finished   = w_result.finished;

endmodule

@@ hw/rtl/mpbs_regs.sv @@
// apb configuration registers: batch size and queue limit
// depends on mpbs_pkg

module mpbs_regs
    import mpbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.batch_size  <= BATCH_SIZE_RST;
            r_cfg.queue_limit <= QUEUE_LIMIT_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_BATCH_SIZE:  r_cfg.batch_size  <= pwdata[15:0];
                REG_QUEUE_LIMIT: r_cfg.queue_limit <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BATCH_SIZE:  prdata = 32'(r_cfg.batch_size);
            REG_QUEUE_LIMIT: prdata = 32'(r_cfg.queue_limit);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/mpbs_core.sv @@
// scheduler state and per-tick decision logic
// depends on mpbs_pkg

module mpbs_core
    import mpbs_pkg::*;
#(
    parameter int unsigned CLOCK_WIDTH = 32,
    parameter int unsigned MAX_QUEUE   = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_cfg    i_cfg,
    input  t_tick   i_tick,
    output t_result o_result
);

    localparam int unsigned OW = $clog2(MAX_QUEUE + 1);
    localparam int unsigned LW = (OW > 7) ? OW : 7;
    localparam int unsigned TW = (CLOCK_WIDTH > 32) ? CLOCK_WIDTH : 32;

    logic [2:0]             r_mode, n_mode;
    logic [CLOCK_WIDTH-1:0] r_clk, n_clk;
    logic [15:0]            r_batch_left, n_batch_left;
    logic                   r_batch_started, n_batch_started;
    logic                   r_pim_started, n_pim_started;
    logic [BUDGET_W-1:0]    r_mem_budget, n_mem_budget;
    logic [BUDGET_W-1:0]    r_pim_budget, n_pim_budget;
    logic [OW-1:0]          r_outstanding, n_outstanding;
    logic                   r_pe_done, n_pe_done;
    logic                   r_trace_done, n_trace_done;

    logic [2:0]    w_mode;
    logic          w_is_mem, w_core_avail, w_can_issue, w_issue, w_drained;
    logic [OW-1:0] w_out_ret;
    logic [LW-1:0] w_limit;
    logic          w_head_present, w_head_arrived, w_want;
    logic [31:0]   w_head_time;
    logic          w_tick, w_pause, w_resume;

    always_comb begin
        w_mode       = (r_mode > MODE_TOMEM) ? MODE_WAIT : r_mode;
        w_is_mem     = (w_mode == MODE_WAIT) || (w_mode == MODE_MEM);
        w_core_avail = i_tick.pe_halted || i_tick.cpu_ready;

        // memory clock first, saturating
        n_clk = r_clk;
        if (w_is_mem && (r_clk != {CLOCK_WIDTH{1'b1}}))
            n_clk = r_clk + 1'b1;

        // retirements, clamped at zero
        if (LW'(i_tick.retired_count) >= LW'(r_outstanding))
            w_out_ret = '0;
        else
            w_out_ret = OW'(LW'(r_outstanding) - LW'(i_tick.retired_count));
        w_drained = (w_out_ret == '0);

        w_limit = (LW'(i_cfg.queue_limit) < LW'(MAX_QUEUE)) ?
                  LW'(i_cfg.queue_limit) : LW'(MAX_QUEUE);

        w_can_issue = 1'b1;
        if (w_mode == MODE_MEM)
            w_can_issue = (r_batch_left != '0) || !w_core_avail || i_tick.pe_halted;

        w_issue = w_can_issue && i_tick.trace_present
                  && (LW'(w_out_ret) < w_limit)
                  && (TW'(i_tick.trace_time) <= TW'(n_clk))
                  && !(!i_tick.trace_is_write && i_tick.read_blocked)
                  && i_tick.dram_accepts;

        n_outstanding = w_issue ? (w_out_ret + 1'b1) : w_out_ret;
        n_batch_left  = r_batch_left;
        if (w_issue && w_is_mem && (r_batch_left != '0))
            n_batch_left = r_batch_left - 1'b1;

        // trace head after a possible pop
        w_head_present = w_issue ? i_tick.next_present : i_tick.trace_present;
        w_head_time    = w_issue ? i_tick.after_time : i_tick.trace_time;
        w_head_arrived = TW'(w_head_time) <= TW'(n_clk);
        w_want         = w_can_issue && w_head_present && w_head_arrived;

        n_mode = w_mode;
        unique case (w_mode)
            MODE_WAIT: begin
                if (n_outstanding != '0)
                    n_mode = MODE_MEM;
                else if (!w_head_present && !i_tick.pe_halted)
                    n_mode = MODE_TOPIM;
            end
            MODE_MEM: begin
                if (!i_tick.pe_halted && r_batch_started && w_core_avail
                    && w_drained && !w_want)
                    n_mode = MODE_TOPIM;
            end
            MODE_TOPIM: begin
                if (i_tick.pe_halted)
                    n_mode = MODE_TOMEM;
                else if (!r_pim_started || i_tick.cpu_ready)
                    n_mode = MODE_PIM;
            end
            MODE_PIM: begin
                if (i_tick.pe_halted || (w_head_present && (r_pim_budget >= r_mem_budget)))
                    n_mode = MODE_TOMEM;
            end
            default: begin
                if (i_tick.pe_halted || i_tick.cpu_ready)
                    n_mode = MODE_WAIT;
            end
        endcase

        n_batch_started = r_batch_started;
        n_pim_started   = r_pim_started;
        n_mem_budget    = r_mem_budget;
        n_pim_budget    = r_pim_budget;
        w_pause         = 1'b0;
        w_resume        = 1'b0;
        w_tick          = 1'b0;

        // entry actions
        if (n_mode != w_mode) begin
            unique case (n_mode)
                MODE_MEM: begin
                    n_batch_started = 1'b1;
                    n_mem_budget    = '0;
                end
                MODE_TOPIM: begin
                    n_outstanding = '0;
                    n_pim_budget  = '0;
                    w_resume      = r_pim_started;
                end
                MODE_PIM: n_pim_started = 1'b1;
                MODE_TOMEM: w_pause = !i_tick.pe_halted && (w_mode == MODE_PIM);
                default: begin
                    n_batch_left    = i_cfg.batch_size;
                    n_batch_started = 1'b0;
                    n_mem_budget    = '0;
                    n_pim_budget    = '0;
                end
            endcase
        end

        // per-mode work after the decision
        unique case (n_mode)
            MODE_MEM: begin
                if (n_mem_budget != {BUDGET_W{1'b1}})
                    n_mem_budget = n_mem_budget + 1'b1;
            end
            MODE_TOPIM: w_tick = n_pim_started;
            MODE_PIM: begin
                w_tick = 1'b1;
                if (n_pim_budget != {BUDGET_W{1'b1}})
                    n_pim_budget = n_pim_budget + 1'b1;
            end
            MODE_TOMEM: w_tick = !i_tick.pe_halted;
            default: ;
        endcase

        n_pe_done    = r_pe_done || i_tick.pe_halted;
        n_trace_done = r_trace_done || (!w_head_present && i_tick.dram_drained);

        o_result.mode       = n_mode;
        o_result.issue      = w_issue;
        o_result.dram_tick  = w_is_mem;
        o_result.cpu_tick   = w_tick;
        o_result.cpu_pause  = w_pause;
        o_result.cpu_resume = w_resume;
        o_result.finished   = n_pe_done && n_trace_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_WAIT;
            r_clk           <= '0;
            r_batch_left    <= BATCH_SIZE_RST;
            r_batch_started <= 1'b0;
            r_pim_started   <= 1'b0;
            r_mem_budget    <= '0;
            r_pim_budget    <= '0;
            r_outstanding   <= '0;
            r_pe_done       <= 1'b0;
            r_trace_done    <= 1'b0;
        end else if (i_load) begin
            r_mode          <= n_mode;
            r_clk           <= n_clk;
            r_batch_left    <= n_batch_left;
            r_batch_started <= n_batch_started;
            r_pim_started   <= n_pim_started;
            r_mem_budget    <= n_mem_budget;
            r_pim_budget    <= n_pim_budget;
            r_outstanding   <= n_outstanding;
            r_pe_done       <= n_pe_done;
            r_trace_done    <= n_trace_done;
        end
    end

endmodule

@@ hw/rtl/mpbs_out_reg.sv @@
// result register with valid/ready toward the consumer
// depends on mpbs_pkg

module mpbs_out_reg
    import mpbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // free when empty or the held result leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
